// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the capture unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- rtl/pdc_pkg.sv -----
// Types and constants of the PWM period and duty capture unit.
package pdc_pkg;
	localparam int TIMER_BITS = 16;
	localparam int TOTAL_W = TIMER_BITS + 1;
	localparam int DUTY_W = 7;
	localparam int NUM_W = TIMER_BITS + DUTY_W;
	localparam int CNT_W = $clog2(DUTY_W);
	localparam int PERCENT_SCALE = 100;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;
endpackage

// ----- rtl/pdc_div.sv -----
// Restoring divider: one compare and subtract per cycle, one quotient bit a step.
`include "assert_macros.svh"
module pdc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pdc_pkg::div_ctl_t                ctl,
	input  logic [pdc_pkg::NUM_W-1:0]        num,
	input  logic [pdc_pkg::TOTAL_W-1:0]      den,
	output pdc_pkg::div_sts_t                sts,
	output logic [pdc_pkg::DUTY_W-1:0]       quot
);
	logic                            busy_q;
	logic                            done_q;
	logic [pdc_pkg::CNT_W-1:0]       cnt_q;
	logic [pdc_pkg::NUM_W-1:0]       rem_q;
	logic [pdc_pkg::DUTY_W-1:0]      quot_q;
	logic [pdc_pkg::NUM_W-1:0]       den_q;
	logic [pdc_pkg::NUM_W-1:0]       shifted;
	logic [pdc_pkg::NUM_W:0]         diff;

	assign shifted = den_q << cnt_q;
	assign diff = {1'b0, rem_q} - {1'b0, shifted};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= pdc_pkg::CNT_W'(pdc_pkg::DUTY_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= num;
			den_q <= pdc_pkg::NUM_W'(den);
			quot_q <= '0;
		end else if (busy_q && !diff[pdc_pkg::NUM_W]) begin
			rem_q <= diff[pdc_pkg::NUM_W-1:0];
			quot_q[cnt_q] <= 1'b1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot = quot_q;

	`ASSERT_CLK(a_start_when_free, clk, arst_n, ctl.start |-> !busy_q, "start while busy")
	`ASSERT_CLK(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q), "done without busy")
	`ASSERT_NEXT(a_last_step, clk, arst_n, busy_q && !ctl.start && cnt_q == '0, !busy_q && done_q,
		"last step did not finish")
endmodule

// ----- rtl/pwm_period_duty_capture_unit.sv -----
// Top level of the PWM period and duty capture unit.
// Input channel: in_valid / in_stall carry one edge item, edge_timestamp, the
// free-running timer value at that edge. Edges alternate, rising first.
// Output channel: out_valid / out_stall carry one result item per edge:
// was_rising, on_period, off_period, total_period, duty_percent, zero_total.
// An edge is taken only while the unit is idle. At acceptance the periods are
// updated and the total and on_period*100 are formed; the next cycle loads the
// divider, which produces one quotient bit per cycle; once it signals done, the
// result moves to the output register as soon as that register is free.
// A new edge is taken only after the result has left the sequencer, so the unit
// does not take an edge before it is through with the last one.
// A stalled result stays in the output register unchanged; the next edge is
// still accepted and computed, and waits in the sequencer for the register.
// Reset clears the edge phase (next edge is rising), the previous stamp and
// both periods to zero, and empties the output register.
`include "assert_macros.svh"
module pwm_period_duty_capture_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [15:0]                        edge_timestamp,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               was_rising,
	output logic [15:0]                        on_period,
	output logic [15:0]                        off_period,
	output logic [16:0]                        total_period,
	output logic [6:0]                         duty_percent,
	output logic                               zero_total
);
	pdc_pkg::state_t                      state_q;
	logic                                 expect_falling_q;
	logic [pdc_pkg::TIMER_BITS-1:0]       prev_q;
	logic [pdc_pkg::TIMER_BITS-1:0]       high_q;
	logic [pdc_pkg::TIMER_BITS-1:0]       low_q;
	logic                                 rising_q;
	logic [pdc_pkg::TOTAL_W-1:0]          total_q;
	logic [pdc_pkg::NUM_W-1:0]            num_q;
	logic                                 out_valid_q;
	logic                                 out_rising_q;
	logic [pdc_pkg::TIMER_BITS-1:0]       out_high_q;
	logic [pdc_pkg::TIMER_BITS-1:0]       out_low_q;
	logic [pdc_pkg::TOTAL_W-1:0]          out_total_q;
	logic [pdc_pkg::DUTY_W-1:0]           out_duty_q;
	logic                                 out_zero_q;
	logic [pdc_pkg::TIMER_BITS-1:0]       stamp;
	logic [pdc_pkg::TIMER_BITS-1:0]       delta;
	logic                                 accept;
	logic                                 out_free;
	logic                                 zero;
	pdc_pkg::div_ctl_t                    div_ctl;
	pdc_pkg::div_sts_t                    div_sts;
	logic [pdc_pkg::DUTY_W-1:0]           quot;

	assign stamp = edge_timestamp[pdc_pkg::TIMER_BITS-1:0];
	assign delta = stamp - prev_q;
	assign in_stall = (state_q != pdc_pkg::ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign zero = (total_q == '0);
	assign div_ctl.start = (state_q == pdc_pkg::ST_CALC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdc_pkg::ST_IDLE;
			expect_falling_q <= 1'b0;
			prev_q <= '0;
			high_q <= '0;
			low_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == pdc_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				pdc_pkg::ST_IDLE: begin
					if (accept) begin
						if (!expect_falling_q) begin
							low_q <= delta;
						end else begin
							high_q <= delta;
						end
						expect_falling_q <= !expect_falling_q;
						prev_q <= stamp;
						state_q <= pdc_pkg::ST_CALC;
					end
				end
				pdc_pkg::ST_CALC: begin
					state_q <= pdc_pkg::ST_DIV;
				end
				pdc_pkg::ST_DIV: begin
					if (div_sts.done) begin
						state_q <= pdc_pkg::ST_OUT;
					end
				end
				pdc_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= pdc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pdc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rising_q <= !expect_falling_q;
			if (!expect_falling_q) begin
				total_q <= {1'b0, high_q} + {1'b0, delta};
				num_q <= pdc_pkg::NUM_W'(high_q) * pdc_pkg::NUM_W'(pdc_pkg::PERCENT_SCALE);
			end else begin
				total_q <= {1'b0, delta} + {1'b0, low_q};
				num_q <= pdc_pkg::NUM_W'(delta) * pdc_pkg::NUM_W'(pdc_pkg::PERCENT_SCALE);
			end
		end
		if (state_q == pdc_pkg::ST_OUT && out_free) begin
			out_rising_q <= rising_q;
			out_high_q <= high_q;
			out_low_q <= low_q;
			out_total_q <= total_q;
			out_duty_q <= zero ? '0 : quot;
			out_zero_q <= zero;
		end
	end

	pdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (num_q),
		.den    (total_q),
		.sts    (div_sts),
		.quot   (quot)
	);

	assign out_valid = out_valid_q;
	assign was_rising = out_rising_q;
	assign on_period = out_high_q;
	assign off_period = out_low_q;
	assign total_period = out_total_q;
	assign duty_percent = out_duty_q;
	assign zero_total = out_zero_q;

	`ASSERT_NEXT(a_accept_calc, clk, arst_n, accept, state_q == pdc_pkg::ST_CALC,
		"accepted item did not start calc")
	`ASSERT_CLK(a_done_in_div, clk, arst_n, div_sts.done |-> state_q == pdc_pkg::ST_DIV,
		"divider done outside div state")
	`ASSERT_CLK(a_zero_duty, clk, arst_n, out_valid_q && out_zero_q |-> out_duty_q == '0,
		"zero total with nonzero duty")
endmodule

// ----- dv/pwm_period_duty_capture_unit_tb.sv -----
// Testbench for the PWM period and duty capture unit: edges in, measurements checked.
`timescale 1ns / 1ps
module pwm_period_duty_capture_unit_tb;
	localparam int RANDOM_EDGES  = 800;
	localparam int HOLD_AT       = 300;
	localparam int HOLD_CYCLES   = 120;
	localparam int PAUSE_AT      = 500;
	localparam int DRAIN_CYCLES  = 20;
	localparam int IDLE_LIMIT    = 1000;
	localparam int REPORT_LIMIT  = 10;
	localparam int DIRECTED_ROWS = 18;

	typedef struct packed {
		logic                           rising;
		logic [pdc_pkg::TIMER_BITS-1:0] on_p;
		logic [pdc_pkg::TIMER_BITS-1:0] off_p;
		logic [pdc_pkg::TOTAL_W-1:0]    total;
		logic [pdc_pkg::DUTY_W-1:0]     duty;
		logic                           zero;
	} measurement_t;

	typedef struct {
		logic [pdc_pkg::TIMER_BITS-1:0] stamp;
		bit                             typed;
		measurement_t                   res;
	} edge_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [pdc_pkg::TIMER_BITS-1:0] edge_timestamp;
	logic                           out_valid;
	logic                           out_stall;
	logic                           was_rising;
	logic [pdc_pkg::TIMER_BITS-1:0] on_period;
	logic [pdc_pkg::TIMER_BITS-1:0] off_period;
	logic [pdc_pkg::TOTAL_W-1:0]    total_period;
	logic [pdc_pkg::DUTY_W-1:0]     duty_percent;
	logic                           zero_total;

	measurement_t                   awaited_measurements[$];
	edge_row_t                      directed_edges[DIRECTED_ROWS];
	int                             mismatches = 0;
	int                             idle_cycles = 0;
	bit                             quiet = 1'b0;
	bit                             hold_req = 1'b0;

	// predicted capture state
	logic                           pred_falling;
	logic [pdc_pkg::TIMER_BITS-1:0] pred_prev;
	logic [pdc_pkg::TIMER_BITS-1:0] pred_on;
	logic [pdc_pkg::TIMER_BITS-1:0] pred_off;

	pwm_period_duty_capture_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.edge_timestamp (edge_timestamp),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.was_rising     (was_rising),
		.on_period      (on_period),
		.off_period     (off_period),
		.total_period   (total_period),
		.duty_percent   (duty_percent),
		.zero_total     (zero_total)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic measurement_t measure_edge(
			input logic [pdc_pkg::TIMER_BITS-1:0] stamp);
		measurement_t                   m;
		logic [pdc_pkg::TIMER_BITS-1:0] delta;
		logic [31:0]                    scaled;
		delta = stamp - pred_prev;
		m.rising = !pred_falling;
		if (m.rising) begin
			pred_off = delta;
		end else begin
			pred_on = delta;
		end
		pred_falling = m.rising;
		pred_prev = stamp;
		m.on_p = pred_on;
		m.off_p = pred_off;
		m.total = {1'b0, pred_on} + {1'b0, pred_off};
		m.zero = (m.total == '0);
		scaled = 32'(pred_on) * pdc_pkg::PERCENT_SCALE;
		m.duty = m.zero ? '0 : pdc_pkg::DUTY_W'(scaled / 32'(m.total));
		return m;
	endfunction

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 4);
	endfunction

	task automatic send_edge(input logic [pdc_pkg::TIMER_BITS-1:0] stamp, input bit typed,
			input measurement_t typed_res, input bit drop_after);
		measurement_t m;
		in_valid <= 1'b1;
		edge_timestamp <= stamp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		m = measure_edge(stamp);
		if (typed) m = typed_res;
		awaited_measurements.push_back(m);
		if (drop_after) in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (awaited_measurements.size() != 0) @(posedge clk);
	endtask

	// sender
	initial begin
		int                             gap;
		logic [pdc_pkg::TIMER_BITS-1:0] cur;
		int                             mode;
		measurement_t                   none;
		none = '0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		edge_timestamp <= '0;
		pred_falling = 1'b0;
		pred_prev = '0;
		pred_on = '0;
		pred_off = '0;

		directed_edges[0]  = '{16'h0000, 1'b1, '{1'b1, 16'h0000, 16'h0000, 17'h00000, 7'd0,   1'b1}};
		directed_edges[1]  = '{16'h0000, 1'b1, '{1'b0, 16'h0000, 16'h0000, 17'h00000, 7'd0,   1'b1}};
		directed_edges[2]  = '{16'hFFFF, 1'b1, '{1'b1, 16'h0000, 16'hFFFF, 17'h0FFFF, 7'd0,   1'b0}};
		directed_edges[3]  = '{16'hFFFE, 1'b1, '{1'b0, 16'hFFFF, 16'hFFFF, 17'h1FFFE, 7'd50,  1'b0}};
		directed_edges[4]  = '{16'hFFFE, 1'b1, '{1'b1, 16'hFFFF, 16'h0000, 17'h0FFFF, 7'd100, 1'b0}};
		directed_edges[5]  = '{16'hFFF0, 1'b0, none};
		directed_edges[6]  = '{16'h0010, 1'b0, none};
		directed_edges[7]  = '{16'h0040, 1'b0, none};
		directed_edges[8]  = '{16'h0041, 1'b0, none};
		directed_edges[9]  = '{16'h0041, 1'b0, none};
		directed_edges[10] = '{16'h0041, 1'b1, '{1'b1, 16'h0000, 16'h0000, 17'h00000, 7'd0,   1'b1}};
		directed_edges[11] = '{16'h8000, 1'b0, none};
		directed_edges[12] = '{16'h8001, 1'b0, none};
		directed_edges[13] = '{16'h5555, 1'b0, none};
		directed_edges[14] = '{16'hAAAA, 1'b0, none};
		directed_edges[15] = '{16'h00FF, 1'b0, none};
		directed_edges[16] = '{16'hFF00, 1'b0, none};
		directed_edges[17] = '{16'h1234, 1'b0, none};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap = draw_gap();
		for (int k = 0; k < DIRECTED_ROWS; k++) begin
			repeat (gap) @(posedge clk);
			gap = draw_gap();
			send_edge(directed_edges[k].stamp, directed_edges[k].typed,
				directed_edges[k].res, gap != 0);
		end
		cur = directed_edges[DIRECTED_ROWS-1].stamp;

		for (int i = 0; i < RANDOM_EDGES; i++) begin
			quiet <= ((i / 100) % 4 == 3);
			if (i == HOLD_AT) hold_req <= 1'b1;
			repeat (gap) @(posedge clk);
			mode = $urandom_range(0, 9);
			case (mode)
				0, 1: cur = 16'($urandom_range(0, 65535));
				2: ;
				3, 4, 5, 6: cur = cur + 16'($urandom_range(1, 300));
				7, 8: cur = cur + 16'($urandom_range(30000, 65535));
				default: cur = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			endcase
			gap = draw_gap();
			send_edge(cur, 1'b0, none, gap != 0 || i == PAUSE_AT || i == RANDOM_EDGES - 1);
			if (i == PAUSE_AT) wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_measurements.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// receiver
	initial begin
		int n;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (arst_n && out_valid && !out_stall) begin
				n = quiet ? 0 : $urandom_range(0, 4);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// result check
	always @(posedge clk) begin
		measurement_t got;
		measurement_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{was_rising, on_period, off_period, total_period, duty_percent, zero_total};
			if (awaited_measurements.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected item: rise=%0d on=%0h off=%0h tot=%0h duty=%0d zero=%0d",
						got.rising, got.on_p, got.off_p, got.total, got.duty, got.zero);
			end else begin
				want = awaited_measurements.pop_front();
				if (got.rising !== want.rising || got.on_p !== want.on_p ||
						got.off_p !== want.off_p || got.total !== want.total ||
						got.duty !== want.duty || got.zero !== want.zero) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch: exp rise=%0d on=%0h off=%0h tot=%0h duty=%0d zero=%0d %s",
							want.rising, want.on_p, want.off_p, want.total, want.duty,
							want.zero, $sformatf("got rise=%0d on=%0h off=%0h tot=%0h duty=%0d zero=%0d",
							got.rising, got.on_p, got.off_p, got.total, got.duty, got.zero));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles + 1 >= IDLE_LIMIT) begin
					$display("FAILURE");
					$finish;
				end
			end
		end
	end
endmodule
